// ----- hw/rtl/bom_pkg.sv -----
`timescale 1ns / 1ps
package bom_pkg;

  localparam int OPC_W     = 2;
  localparam int BOX_W     = 16;
  localparam int BOX_PACK_W = 4 * BOX_W;
  localparam int TAG_W     = 31;
  localparam int CONF_W    = 16;
  localparam int CLASS_W   = 8;
  localparam int THR_W     = 17;
  localparam int SLOT_W    = 4;
  localparam int OUTC_W    = 3;
  localparam int CFG_IDX_W = 1;

  localparam int EDGE_W  = BOX_W + 1;
  localparam int OVL_W   = BOX_W + 2;
  localparam int AREA_W  = 2 * BOX_W;
  localparam int UNI_W   = AREA_W + 1;
  localparam int MUL_A_W = UNI_W;
  localparam int MUL_B_W = THR_W;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int FRAC_W  = 16;

  localparam logic [CONF_W-1:0] PROB_THR_RST = CONF_W'(32768);
  localparam logic [THR_W-1:0]  OVL_THR_RST  = THR_W'(32768);

  typedef enum logic [OPC_W-1:0] {
    OP_CLEAR    = 2'd0,
    OP_LOAD_TRK = 2'd1,
    OP_LOAD_LOC = 2'd2,
    OP_QUERY    = 2'd3
  } opcode_t;

  typedef enum logic [OUTC_W-1:0] {
    OUT_MERGED   = 3'd0,
    OUT_LOW_PROB = 3'd1,
    OUT_NO_TRACK = 3'd2,
    OUT_NO_LOC   = 3'd3,
    OUT_FULL     = 3'd4
  } outcome_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROB_THR = 1'd0,
    REG_OVL_THR  = 1'd1
  } cfg_reg_t;

endpackage

// ----- hw/rtl/box_overlap_merge_core.sv -----
`timescale 1ns / 1ps
// Box overlap merge core.
// Requests enter on start/opcode/box/tag/confidence/class, taken when start is
// high and busy is low. Results appear for one cycle with done high; the
// receiver cannot stall, so each result must be taken in that cycle.
// Clear, table loads and low-probability queries finish in the accept cycle:
// busy stays low and any result (table full, low probability) is registered
// and shows in the next cycle, so such requests may be issued every cycle.
// A detection query runs on one shared 33x17 multiplier under a sequencer:
// first the box area, then for each tracked entry an overlap check and, if
// the boxes overlap, tw*th, w*h, thr*union and a compare. The first tracked
// hit (or a non-overlapping entry when the overlap threshold is zero) starts
// a search of the localized entries for an equal box. The result shows in
// the same cycle as busy falls.
// Threshold registers are written on cfg_valid/cfg_ready while idle
// (cfg_ready is low during a query). Reset empties both tables and restores
// both thresholds to one half; table contents are not cleared.
module box_overlap_merge_core #(
  parameter int MAX_TRACKED   = 16,
  parameter int MAX_LOCALIZED = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [bom_pkg::OPC_W-1:0]     opcode,
  input  logic [bom_pkg::BOX_W-1:0]     box_x,
  input  logic [bom_pkg::BOX_W-1:0]     box_y,
  input  logic [bom_pkg::BOX_W-1:0]     box_w,
  input  logic [bom_pkg::BOX_W-1:0]     box_h,
  input  logic [bom_pkg::TAG_W-1:0]     track_tag,
  input  logic [bom_pkg::CONF_W-1:0]    confidence,
  input  logic [bom_pkg::CLASS_W-1:0]   class_code,
  output logic                          done,
  output logic [bom_pkg::OUTC_W-1:0]    outcome,
  output logic [bom_pkg::TAG_W-1:0]     matched_track,
  output logic [bom_pkg::SLOT_W-1:0]    loc_slot,
  output logic [bom_pkg::CONF_W-1:0]    out_confidence,
  output logic [bom_pkg::CLASS_W-1:0]   out_class,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bom_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bom_pkg::THR_W-1:0]     cfg_data
);
  import bom_pkg::*;

  localparam int TCW = $clog2(MAX_TRACKED + 1);
  localparam int LCW = $clog2(MAX_LOCALIZED + 1);
  localparam int TIW = (MAX_TRACKED > 1) ? $clog2(MAX_TRACKED) : 1;
  localparam int LIW = (MAX_LOCALIZED > 1) ? $clog2(MAX_LOCALIZED) : 1;
  localparam int TRK_ENT_W = TAG_W + BOX_PACK_W;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_AREA,
    ST_DAREA,
    ST_TCHK,
    ST_TGEO,
    ST_TINT,
    ST_TUNI,
    ST_TCMP1,
    ST_TCMP2,
    ST_LCHK,
    ST_LCMP
  } state_t;

  state_t state;

  logic [TCW-1:0]        tcount;
  logic [LCW-1:0]        lcount;
  logic [TCW-1:0]        tidx;
  logic [LCW-1:0]        lidx;
  logic [CONF_W-1:0]     prob_thr;
  logic [THR_W-1:0]      ovl_thr;

  logic [BOX_W-1:0]      qx, qy, qw, qh;
  logic [CONF_W-1:0]     qconf;
  logic [CLASS_W-1:0]    qcls;
  logic [AREA_W-1:0]     darea;
  logic [AREA_W-1:0]     tarea;
  logic [AREA_W-1:0]     inter;
  logic [UNI_W-1:0]      uni;
  logic [BOX_W-1:0]      ow, oh;
  logic [TAG_W-1:0]      hit_id;

  logic [TRK_ENT_W-1:0]  tmem [MAX_TRACKED];
  logic [BOX_PACK_W-1:0] lmem [MAX_LOCALIZED];
  logic [TRK_ENT_W-1:0]  t_rd;
  logic [BOX_PACK_W-1:0] l_rd;

  logic [MUL_A_W-1:0]    mul_a;
  logic [MUL_B_W-1:0]    mul_b;
  logic [MUL_P_W-1:0]    mul_p;

  logic                  accept;
  logic                  t_we, l_we;
  logic [BOX_PACK_W-1:0] in_box, q_box;
  logic [BOX_W-1:0]      t_x, t_y, t_w, t_h;
  logic [OVL_W-1:0]      ov_x, ov_y;
  logic                  ov_pos;
  logic [UNI_W-1:0]      uni_next;
  logic                  iou_hit;
  logic [LIW+SLOT_W-1:0] slot_ext;

  function automatic logic signed [OVL_W-1:0] ov_len(
    input logic [BOX_W-1:0] a, input logic [BOX_W-1:0] la,
    input logic [BOX_W-1:0] b, input logic [BOX_W-1:0] lb
  );
    logic [EDGE_W-1:0] ea, eb, e_max, sum, span;
    logic [BOX_W-1:0]  s_min;
    ea    = EDGE_W'(a) + EDGE_W'(la);
    eb    = EDGE_W'(b) + EDGE_W'(lb);
    e_max = (ea > eb) ? ea : eb;
    s_min = (a < b) ? a : b;
    sum   = EDGE_W'(la) + EDGE_W'(lb);
    span  = e_max - EDGE_W'(s_min);
    return $signed(OVL_W'(sum)) - $signed(OVL_W'(span));
  endfunction

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = !busy;
  assign accept    = start && !busy;

  assign in_box = {box_h, box_w, box_y, box_x};
  assign q_box  = {qh, qw, qy, qx};
  assign t_we   = accept && (opcode_t'(opcode) == OP_LOAD_TRK) &&
                  (tcount < TCW'(MAX_TRACKED));
  assign l_we   = accept && (opcode_t'(opcode) == OP_LOAD_LOC) &&
                  (lcount < LCW'(MAX_LOCALIZED));

  assign t_x = t_rd[BOX_W-1:0];
  assign t_y = t_rd[2*BOX_W-1:BOX_W];
  assign t_w = t_rd[3*BOX_W-1:2*BOX_W];
  assign t_h = t_rd[4*BOX_W-1:3*BOX_W];

  assign ov_x   = ov_len(qx, qw, t_x, t_w);
  assign ov_y   = ov_len(qy, qh, t_y, t_h);
  assign ov_pos = ($signed(ov_x) > 0) && ($signed(ov_y) > 0);

  assign uni_next = UNI_W'(darea) + UNI_W'(tarea) - UNI_W'(mul_p[AREA_W-1:0]);
  assign iou_hit  = MUL_P_W'({inter, FRAC_W'(0)}) >= mul_p;
  assign slot_ext = {SLOT_W'(0), lidx[LIW-1:0]};

  always_comb begin
    unique case (state)
      ST_AREA: begin
        mul_a = MUL_A_W'(qw);
        mul_b = MUL_B_W'(qh);
      end
      ST_TGEO: begin
        mul_a = MUL_A_W'(t_w);
        mul_b = MUL_B_W'(t_h);
      end
      ST_TINT: begin
        mul_a = MUL_A_W'(ow);
        mul_b = MUL_B_W'(oh);
      end
      ST_TCMP1: begin
        mul_a = uni;
        mul_b = ovl_thr;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  bom_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  always_ff @(posedge clk) begin
    if (t_we) begin
      tmem[tcount[TIW-1:0]] <= {track_tag, in_box};
    end
    t_rd <= tmem[tidx[TIW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (l_we) begin
      lmem[lcount[LIW-1:0]] <= in_box;
    end
    l_rd <= lmem[lidx[LIW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      tcount   <= '0;
      lcount   <= '0;
      prob_thr <= PROB_THR_RST;
      ovl_thr  <= OVL_THR_RST;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_PROB_THR: prob_thr <= cfg_data[CONF_W-1:0];
          REG_OVL_THR:  ovl_thr  <= cfg_data;
        endcase
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            qx    <= box_x;
            qy    <= box_y;
            qw    <= box_w;
            qh    <= box_h;
            qconf <= confidence;
            qcls  <= class_code;
            unique case (opcode_t'(opcode))
              OP_CLEAR: begin
                tcount <= '0;
                lcount <= '0;
              end
              OP_LOAD_TRK: begin
                if (t_we) begin
                  tcount <= tcount + 1'b1;
                end else begin
                  done           <= 1'b1;
                  outcome        <= OUT_FULL;
                  matched_track  <= '0;
                  loc_slot       <= '0;
                  out_confidence <= '0;
                  out_class      <= '0;
                end
              end
              OP_LOAD_LOC: begin
                if (l_we) begin
                  lcount <= lcount + 1'b1;
                end else begin
                  done           <= 1'b1;
                  outcome        <= OUT_FULL;
                  matched_track  <= '0;
                  loc_slot       <= '0;
                  out_confidence <= '0;
                  out_class      <= '0;
                end
              end
              OP_QUERY: begin
                if (confidence < prob_thr) begin
                  done           <= 1'b1;
                  outcome        <= OUT_LOW_PROB;
                  matched_track  <= '0;
                  loc_slot       <= '0;
                  out_confidence <= confidence;
                  out_class      <= class_code;
                end else begin
                  state <= ST_AREA;
                end
              end
            endcase
          end
        end
        ST_AREA: begin
          tidx  <= '0;
          state <= ST_DAREA;
        end
        ST_DAREA: begin
          darea <= mul_p[AREA_W-1:0];
          state <= ST_TCHK;
        end
        ST_TCHK: begin
          if (tidx == tcount) begin
            done           <= 1'b1;
            outcome        <= OUT_NO_TRACK;
            matched_track  <= '0;
            loc_slot       <= '0;
            out_confidence <= qconf;
            out_class      <= qcls;
            state          <= ST_IDLE;
          end else begin
            state <= ST_TGEO;
          end
        end
        ST_TGEO: begin
          ow     <= ov_x[BOX_W-1:0];
          oh     <= ov_y[BOX_W-1:0];
          hit_id <= t_rd[TRK_ENT_W-1:BOX_PACK_W];
          if (ov_pos) begin
            state <= ST_TINT;
          end else if (ovl_thr == '0) begin
            lidx  <= '0;
            state <= ST_LCHK;
          end else begin
            tidx  <= tidx + 1'b1;
            state <= ST_TCHK;
          end
        end
        ST_TINT: begin
          tarea <= mul_p[AREA_W-1:0];
          state <= ST_TUNI;
        end
        ST_TUNI: begin
          inter <= mul_p[AREA_W-1:0];
          uni   <= uni_next;
          state <= ST_TCMP1;
        end
        ST_TCMP1: begin
          state <= ST_TCMP2;
        end
        ST_TCMP2: begin
          if (iou_hit) begin
            lidx  <= '0;
            state <= ST_LCHK;
          end else begin
            tidx  <= tidx + 1'b1;
            state <= ST_TCHK;
          end
        end
        ST_LCHK: begin
          if (lidx == lcount) begin
            done           <= 1'b1;
            outcome        <= OUT_NO_LOC;
            matched_track  <= hit_id;
            loc_slot       <= '0;
            out_confidence <= qconf;
            out_class      <= qcls;
            state          <= ST_IDLE;
          end else begin
            state <= ST_LCMP;
          end
        end
        ST_LCMP: begin
          if (l_rd == q_box) begin
            done           <= 1'b1;
            outcome        <= OUT_MERGED;
            matched_track  <= hit_id;
            loc_slot       <= slot_ext[SLOT_W-1:0];
            out_confidence <= qconf;
            out_class      <= qcls;
            state          <= ST_IDLE;
          end else begin
            lidx  <= lidx + 1'b1;
            state <= ST_LCHK;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_end_with_result: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("query ended without a result");

  a_tcount_bound: assert property (@(posedge clk) disable iff (rst)
    tcount <= TCW'(MAX_TRACKED))
    else $error("tracked count beyond capacity");

  a_lcount_bound: assert property (@(posedge clk) disable iff (rst)
    lcount <= LCW'(MAX_LOCALIZED))
    else $error("localized count beyond capacity");

  a_full_clean: assert property (@(posedge clk) disable iff (rst)
    (done && outcome == OUT_FULL) |->
      (matched_track == '0 && out_confidence == '0 && out_class == '0))
    else $error("table-full result carries payload");

endmodule

// ----- hw/rtl/bom_mul.sv -----
`timescale 1ns / 1ps
module bom_mul (
  input  logic                        clk,
  input  logic [bom_pkg::MUL_A_W-1:0] a,
  input  logic [bom_pkg::MUL_B_W-1:0] b,
  output logic [bom_pkg::MUL_P_W-1:0] p
);
  import bom_pkg::*;

  always_ff @(posedge clk) begin
    p <= MUL_P_W'(a) * MUL_P_W'(b);
  end

endmodule
